[src/vllc_pkg.sv]
// Shared types and constants for the vehicle LED light controller.
// Depends on nothing; imported by every module of the block.
package vllc_pkg;

    localparam int SIDE_LAMPS        = 4;
    localparam int TOP_LAMPS_DEF     = 4;
    localparam int RESET_BRIGHT_DEF  = 255;

    localparam int COLOR_W  = 24;
    localparam int PERIOD_W = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHASE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CHASE_PER   = 3'd6;

    localparam logic [COLOR_W-1:0]  FRONT_RST     = 24'hF0F0C4;
    localparam logic [COLOR_W-1:0]  BACK_RST      = 24'hFF0000;
    localparam logic [COLOR_W-1:0]  TOP_RST       = 24'hC8960A;
    localparam logic [COLOR_W-1:0]  BLINK_RST     = 24'hFF6400;
    localparam logic [COLOR_W-1:0]  CHASE_RST     = 24'h000000;
    localparam logic [PERIOD_W-1:0] BLINK_PER_RST = 16'd1000;
    localparam logic [PERIOD_W-1:0] CHASE_PER_RST = 16'd100;

    // Remainder unit: bits of the dividend retired per cycle
    localparam int MOD_BITS  = 2;
    localparam int MOD_STEPS = TIME_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    typedef struct packed {
        logic [31:0] now_ms;
        logic [1:0]  indicate_mode;
        logic        loading_on;
        logic [7:0]  brightness;
    } upd_t;

    typedef struct packed {
        logic [2:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } lamp_t;

    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture update, start remainder unit
        logic eval;   // resolve new lamp codes and change mask
        logic emit;   // load output register with current lamp
        logic step;   // advance lamp scan index
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mod_busy;
        logic mask_bit;
        logic idx_last;
        logic slot_free;
    } stat_t;

endpackage

[src/vllc_mod.sv]
// Remainder unit: now_ms modulo blink period, restoring, MOD_BITS bits a cycle.
// Depends on vllc_pkg.
module vllc_mod
    import vllc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TIME_W-1:0]   dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output logic                busy,
    output logic [PERIOD_W-1:0] rem
);

    logic [TIME_W-1:0]    num_reg, num_next;
    logic [PERIOD_W-1:0]  den_reg;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    always_comb
    begin
        logic [PERIOD_W:0] trial;
        trial    = '0;
        rem_next = rem_reg;
        num_next = num_reg;
        for (int k = 0; k < MOD_BITS; k++)
        begin
            trial    = {rem_next, num_next[TIME_W-1]};
            num_next = num_next << 1;
            if (trial >= {1'b0, den_reg})
            begin
                trial = trial - {1'b0, den_reg};
            end
            rem_next = trial[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

[src/vllc_ctrl.sv]
// Sequencer: accept update, wait for remainder, evaluate, scan lamps out.
// Depends on vllc_pkg.
module vllc_ctrl
    import vllc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  upd_valid,
    output logic  upd_stall,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_EVAL,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   stall_reg;
    logic   scan_done;

    // last lamp of the scan is finished this cycle: skipped or handed over
    assign scan_done = st.idx_last && (!st.mask_bit || st.slot_free);

    always_comb
    begin
        cmd      = '0;
        cmd.load = (state_reg == S_IDLE) && upd_valid;
        cmd.eval = (state_reg == S_EVAL);
        cmd.emit = (state_reg == S_EMIT) && st.mask_bit && st.slot_free;
        cmd.step = (state_reg == S_EMIT) && (!st.mask_bit || st.slot_free)
                   && !st.idx_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (upd_valid)
                    begin
                        state_reg <= S_MOD;
                        stall_reg <= 1'b1;
                    end
                end
                S_MOD:
                begin
                    if (!st.mod_busy)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (scan_done)
                    begin
                        state_reg <= S_IDLE;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    stall_reg <= 1'b0;
                end
            endcase
        end
    end

    assign upd_stall = stall_reg;

endmodule

[src/vllc_dpath.sv]
// Datapath: config registers, lamp codes, chase state, change mask, scaler, output beat.
// Depends on vllc_pkg and vllc_mod.
module vllc_dpath
    import vllc_pkg::*;
#(
    parameter int TOP_LAMPS        = TOP_LAMPS_DEF,
    parameter int RESET_BRIGHTNESS = RESET_BRIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,
    input  upd_t                 upd,
    input  cmd_t                 cmd,
    output stat_t                st,
    input  logic                 lamp_stall,
    output logic                 lamp_valid,
    output lamp_t                lamp
);

    localparam int ALL_LAMPS = SIDE_LAMPS + TOP_LAMPS;
    localparam int LAMP_W    = $clog2(ALL_LAMPS);
    localparam int POS_W     = $clog2(TOP_LAMPS);

    typedef enum logic [1:0] {
        LC_DEFAULT = 2'd0,
        LC_BLINK   = 2'd1,
        LC_CHASE   = 2'd2
    } lamp_code_t;

    function automatic logic [COLOR_W-1:0] pick(
        input lamp_code_t         code,
        input logic [COLOR_W-1:0] dflt,
        input logic [COLOR_W-1:0] blink,
        input logic [COLOR_W-1:0] chase
    );
        logic [COLOR_W-1:0] c;
        case (code)
            LC_BLINK: c = blink;
            LC_CHASE: c = chase;
            default:  c = dflt;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] b);
        logic [15:0] p;
        p = c * b;
        return p[15:8];
    endfunction

    // configuration
    logic [COLOR_W-1:0]  front_reg, back_reg, top_reg, blink_reg, chase_reg;
    logic [PERIOD_W-1:0] blink_per_reg, chase_per_reg;

    // block state
    lamp_code_t          code_reg [ALL_LAMPS];
    logic [POS_W-1:0]    pos_reg;
    logic [TIME_W-1:0]   chase_time_reg;
    logic [7:0]          bright_reg;

    // per update
    upd_t                upd_reg;
    logic [ALL_LAMPS-1:0] mask_reg;
    logic [LAMP_W-1:0]   idx_reg;

    // output beat
    logic                lamp_valid_reg;
    lamp_t               lamp_reg;

    logic                mod_busy;
    logic [PERIOD_W-1:0] mod_rem;

    logic [COLOR_W-1:0]  dflt_color [ALL_LAMPS];
    lamp_code_t          code_next  [ALL_LAMPS];
    logic [ALL_LAMPS-1:0] mask_next;
    logic                phase;
    logic                chase_step;
    logic [TIME_W-1:0]   elapsed;
    logic [POS_W-1:0]    pos_next;
    logic                later;
    logic [COLOR_W-1:0]  emit_color;
    logic                slot_free;

    vllc_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (upd.now_ms),
        .divisor  (blink_per_reg),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= FRONT_RST;
            back_reg      <= BACK_RST;
            top_reg       <= TOP_RST;
            blink_reg     <= BLINK_RST;
            chase_reg     <= CHASE_RST;
            blink_per_reg <= BLINK_PER_RST;
            chase_per_reg <= CHASE_PER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRONT:     front_reg     <= cfg_data;
                CFG_BACK:      back_reg      <= cfg_data;
                CFG_TOP:       top_reg       <= cfg_data;
                CFG_BLINK:     blink_reg     <= cfg_data;
                CFG_CHASE:     chase_reg     <= cfg_data;
                CFG_BLINK_PER: blink_per_reg <= cfg_data[PERIOD_W-1:0];
                CFG_CHASE_PER: chase_per_reg <= cfg_data[PERIOD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < ALL_LAMPS; i++)
        begin
            if (i < 2)
            begin
                dflt_color[i] = back_reg;
            end
            else if (i < SIDE_LAMPS)
            begin
                dflt_color[i] = front_reg;
            end
            else
            begin
                dflt_color[i] = top_reg;
            end
        end
    end

    // blink phase: second half of the period shows the indicator color
    assign phase = (blink_per_reg != '0) && (mod_rem >= {1'b0, blink_per_reg[PERIOD_W-1:1]});

    assign elapsed    = upd_reg.now_ms - chase_time_reg;
    assign chase_step = upd_reg.loading_on && (elapsed > {16'b0, chase_per_reg});
    assign pos_next   = (pos_reg == POS_W'(TOP_LAMPS - 1)) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        for (int i = 0; i < ALL_LAMPS; i++)
        begin
            code_next[i] = LC_DEFAULT;
        end
        if (upd_reg.indicate_mode == MODE_LEFT)
        begin
            code_next[0] = phase ? LC_BLINK : LC_DEFAULT;
            code_next[2] = phase ? LC_BLINK : LC_DEFAULT;
        end
        else if (upd_reg.indicate_mode == MODE_RIGHT)
        begin
            code_next[1] = phase ? LC_BLINK : LC_DEFAULT;
            code_next[3] = phase ? LC_BLINK : LC_DEFAULT;
        end
        if (chase_step)
        begin
            for (int i = 0; i < TOP_LAMPS; i++)
            begin
                if (pos_reg == POS_W'(i))
                begin
                    code_next[SIDE_LAMPS + i] = LC_CHASE;
                end
            end
        end
        for (int i = 0; i < ALL_LAMPS; i++)
        begin
            mask_next[i] = (upd_reg.brightness != bright_reg)
                || (pick(code_next[i], dflt_color[i], blink_reg, chase_reg)
                    != pick(code_reg[i], dflt_color[i], blink_reg, chase_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALL_LAMPS; i++)
            begin
                code_reg[i] <= LC_DEFAULT;
            end
            pos_reg        <= '0;
            chase_time_reg <= '0;
            bright_reg     <= 8'(RESET_BRIGHTNESS);
            idx_reg        <= '0;
            mask_reg       <= '0;
        end
        else if (cmd.eval)
        begin
            for (int i = 0; i < ALL_LAMPS; i++)
            begin
                code_reg[i] <= code_next[i];
            end
            if (chase_step)
            begin
                pos_reg        <= pos_next;
                chase_time_reg <= upd_reg.now_ms;
            end
            bright_reg <= upd_reg.brightness;
            mask_reg   <= mask_next;
            idx_reg    <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            upd_reg <= upd;
        end
    end

    // any changed lamp still ahead of the scan index
    always_comb
    begin
        later = 1'b0;
        for (int j = 0; j < ALL_LAMPS; j++)
        begin
            if (LAMP_W'(j) > idx_reg)
            begin
                later = later | mask_reg[j];
            end
        end
    end

    assign emit_color = pick(code_reg[idx_reg], dflt_color[idx_reg], blink_reg, chase_reg);
    assign slot_free  = !lamp_valid_reg || !lamp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            lamp_valid_reg <= 1'b1;
        end
        else if (!lamp_stall)
        begin
            lamp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            lamp_reg.led_index <= idx_reg[2:0];
            lamp_reg.red       <= scale(emit_color[23:16], upd_reg.brightness);
            lamp_reg.green     <= scale(emit_color[15:8],  upd_reg.brightness);
            lamp_reg.blue      <= scale(emit_color[7:0],   upd_reg.brightness);
            lamp_reg.last      <= !later;
        end
    end

    assign st.mod_busy  = mod_busy;
    assign st.mask_bit  = mask_reg[idx_reg];
    assign st.idx_last  = (idx_reg == LAMP_W'(ALL_LAMPS - 1));
    assign st.slot_free = slot_free;

    assign lamp_valid = lamp_valid_reg;
    assign lamp       = lamp_reg;

    a_emit_on_mask: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> mask_reg[idx_reg])
        else $error("beat emitted for an unchanged lamp");

    a_eval_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> !mod_busy)
        else $error("evaluation while remainder unit busy");

    a_emit_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (lamp_valid_reg && lamp_stall) |-> !cmd.emit)
        else $error("output beat overwritten while stalled");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(TOP_LAMPS - 1))
        else $error("chase position out of range");

endmodule

[src/vehicle_led_light_controller_core.sv]
// Top level of the vehicle LED light controller: sequencer plus datapath.
// Depends on vllc_pkg, vllc_ctrl, vllc_dpath (and vllc_mod below it).
//
//  Channel  | Direction | Handshake              | Beat contents
//  ---------+-----------+------------------------+------------------------------------
//  upd      | in        | upd_valid / upd_stall  | now_ms, indicate_mode, loading_on,
//           |           |                        | brightness
//  lamp     | out       | lamp_valid / lamp_stall| led_index, red, green, blue, last
//  cfg      | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// Sequence: an update waits on the remainder unit (now_ms mod blink period,
//   2 bits a cycle), is then evaluated, and the scan takes one lamp per cycle
//   unless stalled on lamp; the sequencer then returns to idle before the
//   next accept.
// The scan sends one beat per changed lamp in ascending order; last marks the
//   final beat of the update. An update with no change sends nothing.
// The output register lets a new update be taken while the final beat waits.
// Reset (rst_n, async, active low) restores the default colors and periods,
//   all lamps to their default code, chase state to zero, brightness memory to
//   RESET_BRIGHTNESS.
module vehicle_led_light_controller_core
    import vllc_pkg::*;
#(
    parameter int TOP_LAMPS        = TOP_LAMPS_DEF,
    parameter int RESET_BRIGHTNESS = RESET_BRIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,

    // update beats
    input  logic                 upd_valid,
    output logic                 upd_stall,
    input  upd_t                 upd,

    // lamp write beats
    output logic                 lamp_valid,
    input  logic                 lamp_stall,
    output lamp_t                lamp
);

    cmd_t  cmd;
    stat_t st;

    // sequencer: owns upd_stall, issues load / eval / emit / step
    vllc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_valid (upd_valid),
        .upd_stall (upd_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: registers, remainder unit, lamp codes, scaler, output beat
    vllc_dpath #(
        .TOP_LAMPS        (TOP_LAMPS),
        .RESET_BRIGHTNESS (RESET_BRIGHTNESS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .upd        (upd),
        .cmd        (cmd),
        .st         (st),
        .lamp_stall (lamp_stall),
        .lamp_valid (lamp_valid),
        .lamp       (lamp)
    );

endmodule
